>>> rtl/b64d_pkg.sv
package b64d_pkg;

    // widths of the counters and fields
    localparam int COUNT_WIDTH = 20;
    localparam int CAP_WIDTH   = 20;
    localparam int BCNT_WIDTH  = 20;
    localparam int JOB_DEPTH   = 4;

    // codes of the input command and the result kind
    localparam logic CMD_CHAR    = 1'b0;
    localparam logic CMD_FINISH  = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    // sextets of the two punctuation characters and alphabet offsets
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [7:0] LOWER_BIAS   = 8'd71;   // 'a' - 26
    localparam logic [7:0] DIGIT_BIAS   = 8'd4;    // 52 - '0'

    localparam logic [BCNT_WIDTH-1:0] CAP_RESET = '1;

    typedef struct packed {
        logic       command;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            data_byte;
        logic [BCNT_WIDTH-1:0] byte_count;
        logic                  overflow_error;
        logic                  last;
    } out_item_t;

    // one queued job: decoded bytes of one item plus an optional done report
    typedef struct packed {
        logic                  finish;
        logic [1:0]            nbytes;
        logic [2:0][7:0]       bytes;
        logic [BCNT_WIDTH-1:0] count;
        logic                  err;
    } job_t;

    // alphabet lookup: bit 6 set when the code is a base64 character
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] r;
        r = '0;
        if (ch >= "A" && ch <= "Z") begin
            r = {1'b1, 6'(ch - 8'(65))};
        end else if (ch >= "a" && ch <= "z") begin
            r = {1'b1, 6'(ch - LOWER_BIAS)};
        end else if (ch >= "0" && ch <= "9") begin
            r = {1'b1, 6'(ch + DIGIT_BIAS)};
        end else if (ch == "+") begin
            r = {1'b1, SEXTET_PLUS};
        end else if (ch == "/") begin
            r = {1'b1, SEXTET_SLASH};
        end
        return r;
    endfunction

    function automatic logic [7:0] byte0(input logic [5:0] a, input logic [5:0] b);
        return {a, b[5:4]};
    endfunction

    function automatic logic [7:0] byte1(input logic [5:0] b, input logic [5:0] c);
        return {b[3:0], c[5:2]};
    endfunction

    function automatic logic [7:0] byte2(input logic [5:0] c, input logic [5:0] d);
        return {c[1:0], d};
    endfunction

endpackage

>>> rtl/b64d_front.sv
module b64d_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  b64d_pkg::in_item_t                   item,
    input  logic                                 cfg_write,
    input  logic [b64d_pkg::CAP_WIDTH-1:0]       cfg_data,
    input  logic                                 job_full,
    output logic                                 full,
    output logic                                 job_push,
    output b64d_pkg::job_t                       job
);

    localparam int CW   = b64d_pkg::COUNT_WIDTH;
    localparam int WIDE = ((CW > b64d_pkg::CAP_WIDTH) ? CW : b64d_pkg::CAP_WIDTH) + 1;

    logic [b64d_pkg::CAP_WIDTH-1:0] cap_reg;
    logic [5:0]                     pend_reg  [3];
    logic [5:0]                     pend_next [3];
    logic [1:0]                     cnt_reg, cnt_next;
    logic [CW-1:0]                  bytes_reg, bytes_next;
    logic                           err_reg, err_next;

    logic            accept;
    logic [6:0]      sx;
    logic [WIDE-1:0] eff_cap, cap_w, max_w, sum3, sum_fl;
    logic [1:0]      need;

    assign full   = job_full;
    assign accept = push && !full;
    assign sx     = b64d_pkg::sextet_of(item.symbol);

    // capacity saturated at what the byte counter can hold
    assign cap_w   = WIDE'(cap_reg);
    assign max_w   = WIDE'({CW{1'b1}});
    assign eff_cap = (cap_w < max_w) ? cap_w : max_w;
    assign need    = cnt_reg - 2'd1;
    assign sum3    = WIDE'(bytes_reg) + WIDE'(3);
    assign sum_fl  = WIDE'(bytes_reg) + WIDE'(need);

    // classify the item and update the decoder state
    always_comb
    begin
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        err_next   = err_reg;
        job_push   = 1'b0;
        job        = '0;
        if (accept) begin
            if (item.command == b64d_pkg::CMD_CHAR) begin
                if (!err_reg && sx[6]) begin
                    if (cnt_reg != 2'd3) begin
                        pend_next[cnt_reg] = sx[5:0];
                        cnt_next           = cnt_reg + 2'd1;
                    end else begin
                        cnt_next = 2'd0;
                        if (sum3 > eff_cap) begin
                            err_next = 1'b1;
                        end else begin
                            job_push     = 1'b1;
                            job.nbytes   = 2'd3;
                            job.bytes[0] = b64d_pkg::byte0(pend_reg[0], pend_reg[1]);
                            job.bytes[1] = b64d_pkg::byte1(pend_reg[1], pend_reg[2]);
                            job.bytes[2] = b64d_pkg::byte2(pend_reg[2], sx[5:0]);
                            bytes_next   = CW'(sum3);
                        end
                    end
                end
            end else begin
                job_push   = 1'b1;
                job.finish = 1'b1;
                if (!err_reg && cnt_reg[1]) begin
                    if (sum_fl > eff_cap) begin
                        err_next = 1'b1;
                    end else begin
                        job.nbytes   = need;
                        job.bytes[0] = b64d_pkg::byte0(pend_reg[0], pend_reg[1]);
                        job.bytes[1] = b64d_pkg::byte1(pend_reg[1], pend_reg[2]);
                        bytes_next   = CW'(sum_fl);
                    end
                end
                job.count  = b64d_pkg::BCNT_WIDTH'(bytes_next);
                job.err    = err_next;
                // finish clears everything but the capacity
                pend_next  = '{default: '0};
                cnt_next   = 2'd0;
                bytes_next = '0;
                err_next   = 1'b0;
            end
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= b64d_pkg::CAP_RESET;
        end else if (cfg_write) begin
            cap_reg <= cfg_data;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg  <= '{default: '0};
            cnt_reg   <= 2'd0;
            bytes_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> rtl/b64d_job_fifo.sv
module b64d_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::job_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output b64d_pkg::job_t head
);

    localparam int DEPTH = b64d_pkg::JOB_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    b64d_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [CNTW-1:0] fill_reg;
    logic            do_push, do_pop;

    assign full    = (fill_reg == CNTW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNTW'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNTW'(1);
            end
        end
    end

endmodule

>>> rtl/b64d_back.sv
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  b64d_pkg::job_t      job,
    output logic                job_pop,
    input  logic                pop,
    output logic                empty,
    output b64d_pkg::out_item_t result
);

    logic                 out_valid_reg;
    b64d_pkg::out_item_t  out_reg, out_next;
    logic [1:0]           idx_reg;
    logic                 load, is_data, job_last;

    assign load     = !job_empty && (!out_valid_reg || pop);
    assign is_data  = (idx_reg < job.nbytes);
    assign job_last = is_data ? ((idx_reg == job.nbytes - 2'd1) && !job.finish) : 1'b1;
    assign job_pop  = load && job_last;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // build the next result of the head job
    always_comb
    begin
        out_next = '0;
        if (is_data) begin
            out_next.kind      = b64d_pkg::KIND_DATA;
            out_next.data_byte = job.bytes[idx_reg];
        end else begin
            out_next.kind           = b64d_pkg::KIND_DONE;
            out_next.byte_count     = job.count;
            out_next.overflow_error = job.err;
        end
        out_next.last = job_last;
    end

    // output register and result index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= job_last ? 2'd0 : idx_reg + 2'd1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> rtl/base64_decoder.sv
// base64 decoder, one text character or one finish command per transfer.
// input side: drive item and raise push; the transfer happens on a clock
// edge with push high and full low. item.command selects a character or
// the end of text; characters outside the base64 alphabet are skipped.
// result side: while empty is low the oldest result sits on result, and a
// clock edge with pop high takes it. each group of four characters gives
// three data bytes; a finish gives the flushed bytes and a done report with
// the byte count and overflow flag. last marks an item's final result.
// cfg_write with cfg_data sets the output capacity; the user must write it
// only while idle, the block itself does not enforce this. the first result
// of an item passes through the job queue and the output register before it
// shows on result. throughput: one item per cycle while full is low, one
// result per cycle while pop is high and a job is queued; the front decodes
// an item in its transfer cycle and queues up to four jobs. a stalled
// receiver fills the job queue and then full rises; nothing is lost. reset
// clears the decoder state and queue and sets the capacity to its maximum.
module base64_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  b64d_pkg::in_item_t             item,
    output logic                           empty,
    input  logic                           pop,
    output b64d_pkg::out_item_t            result,
    input  logic                           cfg_write,
    input  logic [b64d_pkg::CAP_WIDTH-1:0] cfg_data
);

    logic           job_push, job_full, job_empty, job_pop;
    b64d_pkg::job_t job_in, job_head;

    // classify items and update state
    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .job_full  (job_full),
        .full      (full),
        .job_push  (job_push),
        .job       (job_in)
    );

    // queue between front and back
    b64d_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .full      (job_full),
        .empty     (job_empty),
        .head      (job_head)
    );

    // emit results one at a time
    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

>>> rtl/b64d_checker.sv
module b64d_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           push,
    input logic                           full,
    input b64d_pkg::in_item_t             item,
    input logic                           empty,
    input logic                           pop,
    input b64d_pkg::out_item_t            result,
    input logic                           cfg_write,
    input logic [b64d_pkg::CAP_WIDTH-1:0] cfg_data
);

    // a waiting result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while stalled");

    // a done report always closes its item's run
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.kind == b64d_pkg::KIND_DONE |-> result.last)
        else $error("done report without last");

    // data bytes carry no count and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.kind == b64d_pkg::KIND_DATA
            |-> result.byte_count == '0 && !result.overflow_error)
        else $error("data result with report fields set");

    // done reports carry a zero data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.kind == b64d_pkg::KIND_DONE |-> result.data_byte == 8'd0)
        else $error("done report with data byte set");

endmodule

bind base64_decoder b64d_checker u_checker (.*);
